// File: design/cfb_pkg.sv
// Shared types and constants for the command frame builder.
`timescale 1ns / 1ps
`default_nettype none
package cfb_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 58;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] START_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;
  localparam logic [7:0] LEN_OVERHEAD     = 8'd2;
  localparam logic [7:0] CHK_BASE         = 8'hFF;

  // configuration register indexes
  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  // input command codes
  localparam logic CMD_OPEN = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // beat positions within a frame; a payload job begins at STEP_DATA
  localparam logic [2:0] STEP_START = 3'd0;
  localparam logic [2:0] STEP_LEN   = 3'd1;
  localparam logic [2:0] STEP_ID    = 3'd2;
  localparam logic [2:0] STEP_DATA  = 3'd3;
  localparam logic [2:0] STEP_CHK   = 3'd4;
  localparam logic [2:0] STEP_END   = 3'd5;

  typedef enum logic [1:0] {
    JOB_REJECT,
    JOB_HEADER,
    JOB_PAYLOAD
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic       trailer;
    logic [7:0] data;
    logic [7:0] len;
    logic [7:0] id;
    logic [7:0] chk;
  } job_t;

endpackage
`default_nettype wire

// File: design/cfb_front.sv
// Front end: accepts input beats, tracks frame state and classifies each beat into a job.
`timescale 1ns / 1ps
`default_nettype none
module cfb_front #(
  parameter int unsigned MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          command_i,
  input  wire logic [7:0]    cmd_code_i,
  input  wire logic [5:0]    payload_length_i,
  input  wire logic [7:0]    payload_byte_i,
  output cfb_pkg::job_t      job_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [7:0] msg_q, msg_d;
  logic [7:0] sum_q, sum_d;
  logic [5:0] left_q, left_d;
  logic       open_q, open_d;

  logic [7:0] len8;
  logic [7:0] sum_new;
  logic [5:0] left_dec;

  assign len8     = {2'b00, payload_length_i};
  assign left_dec = left_q - 6'd1;

  always_comb begin
    msg_d         = msg_q;
    sum_d         = sum_q;
    left_d        = left_q;
    open_d        = open_q;
    sum_new       = sum_q;
    job_o.kind    = cfb_pkg::JOB_REJECT;
    job_o.trailer = 1'b0;
    job_o.data    = payload_byte_i;
    job_o.len     = cfb_pkg::LEN_OVERHEAD + len8;
    job_o.id      = msg_q;
    job_o.chk     = cfb_pkg::CHK_BASE;
    if (command_i == cfb_pkg::CMD_OPEN) begin
      if (len8 <= MaxLen) begin
        // a new start abandons any unfinished frame
        sum_new    = msg_q + cmd_code_i;
        msg_d      = msg_q + 8'd1;
        sum_d      = sum_new;
        job_o.kind = cfb_pkg::JOB_HEADER;
        job_o.data = cmd_code_i;
        if (payload_length_i == 6'd0) begin
          job_o.trailer = 1'b1;
          open_d        = 1'b0;
          left_d        = 6'd0;
        end else begin
          open_d = 1'b1;
          left_d = payload_length_i;
        end
      end
    end else if (open_q && (left_q != 6'd0)) begin
      sum_new    = sum_q + payload_byte_i;
      sum_d      = sum_new;
      left_d     = left_dec;
      job_o.kind = cfb_pkg::JOB_PAYLOAD;
      if (left_dec == 6'd0) begin
        job_o.trailer = 1'b1;
        open_d        = 1'b0;
      end
    end
    job_o.chk = cfb_pkg::CHK_BASE - sum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_q  <= '0;
      sum_q  <= '0;
      left_q <= '0;
      open_q <= 1'b0;
    end else if (accept_i) begin
      msg_q  <= msg_d;
      sum_q  <= sum_d;
      left_q <= left_d;
      open_q <= open_d;
    end
  end

endmodule
`default_nettype wire

// File: design/cfb_queue.sv
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cfb_queue #(
  parameter int unsigned QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cfb_pkg::job_t push_job_i,
  input  wire logic          pop_i,
  output cfb_pkg::job_t      head_job_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  cfb_pkg::job_t   slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign head_job_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/cfb_back.sv
// Back end: expands queued jobs into output beats through an output register.
`timescale 1ns / 1ps
`default_nettype none
module cfb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfb_pkg::job_t head_job_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  input  wire logic [7:0]    start_marker_i,
  input  wire logic [7:0]    end_marker_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               frame_end_o,
  output logic               rejected_o
);

  logic [2:0] step_q, step_d;
  logic [2:0] pos;
  logic [2:0] last_pos;
  logic       issue;
  logic       last;
  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       fend_q, fend_d;
  logic       rej_q, rej_d;

  assign issue = !empty_i && (!out_valid_q || !out_stall_i);

  // position within the frame: payload jobs start at the data slot
  always_comb begin
    pos      = step_q;
    last_pos = head_job_i.trailer ? cfb_pkg::STEP_END : cfb_pkg::STEP_DATA;
    case (head_job_i.kind)
      cfb_pkg::JOB_PAYLOAD: pos = cfb_pkg::STEP_DATA + step_q;
      default:              pos = step_q;
    endcase
    last = (head_job_i.kind == cfb_pkg::JOB_REJECT) || (pos == last_pos);
  end

  always_comb begin
    byte_d = head_job_i.data;
    fend_d = 1'b0;
    rej_d  = 1'b0;
    if (head_job_i.kind == cfb_pkg::JOB_REJECT) begin
      byte_d = 8'h00;
      rej_d  = 1'b1;
    end else begin
      case (pos)
        cfb_pkg::STEP_START: byte_d = start_marker_i;
        cfb_pkg::STEP_LEN:   byte_d = head_job_i.len;
        cfb_pkg::STEP_ID:    byte_d = head_job_i.id;
        cfb_pkg::STEP_DATA:  byte_d = head_job_i.data;
        cfb_pkg::STEP_CHK:   byte_d = head_job_i.chk;
        cfb_pkg::STEP_END: begin
          byte_d = end_marker_i;
          fend_d = 1'b1;
        end
        default:             byte_d = head_job_i.data;
      endcase
    end
  end

  always_comb begin
    step_d = step_q;
    pop_o  = 1'b0;
    if (issue) begin
      if (last) begin
        step_d = 3'd0;
        pop_o  = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk_i) begin
    if (issue) begin
      byte_q <= byte_d;
      fend_q <= fend_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign frame_end_o = fend_q;
  assign rejected_o  = rej_q;

endmodule
`default_nettype wire

// File: design/command_frame_builder.sv
// Each input beat is registered in the job queue, then in the output register.
// Throughput: one input beat per cycle while the job queue has room; one output
// beat per cycle from the sequencer when not stalled (header 4, trailer 2, payload 1,
// reject 1 beats); the sequencer's single-beat output register sets the output rate.
// Reset clears frame state, message counter, queue and output valid; markers
// return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module command_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       command_i,
  input  wire logic [7:0] cmd_code_i,
  input  wire logic [5:0] payload_length_i,
  input  wire logic [7:0] payload_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o,
  output logic            rejected_o
);

  logic [7:0]    start_marker_q;
  logic [7:0]    end_marker_q;
  logic          accept;
  logic          full;
  logic          empty;
  logic          pop;
  cfb_pkg::job_t new_job;
  cfb_pkg::job_t head_job;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= cfb_pkg::START_MARKER_RST;
      end_marker_q   <= cfb_pkg::END_MARKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfb_pkg::CFG_START_MARKER: start_marker_q <= cfg_wdata_i;
        cfb_pkg::CFG_END_MARKER:   end_marker_q   <= cfg_wdata_i;
        default:                   start_marker_q <= start_marker_q;
      endcase
    end
  end

  cfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .command_i        (command_i),
    .cmd_code_i       (cmd_code_i),
    .payload_length_i (payload_length_i),
    .payload_byte_i   (payload_byte_i),
    .job_o            (new_job)
  );

  cfb_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .full_o     (full),
    .empty_o    (empty)
  );

  cfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_job_i     (head_job),
    .empty_i        (empty),
    .pop_o          (pop),
    .start_marker_i (start_marker_q),
    .end_marker_i   (end_marker_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .rejected_o     (rejected_o)
  );

endmodule
`default_nettype wire

// File: verif/tb_command_frame_builder.sv
// Self-checking testbench for the command frame builder: directed and random frames vs a scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       rej;
} frame_beat_t;

class frame_scoreboard;
  frame_beat_t      expected_beats[$];
  logic [7:0]       start_mark;
  logic [7:0]       end_mark;
  logic [7:0]       next_id;
  logic [7:0]       running_sum;
  logic [5:0]       remaining;
  bit               frame_live;
  int unsigned      errors;

  function new();
    start_mark  = cfb_pkg::START_MARKER_RST;
    end_mark    = cfb_pkg::END_MARKER_RST;
    next_id     = '0;
    running_sum = '0;
    remaining   = '0;
    frame_live  = 1'b0;
    errors      = 0;
  endfunction

  function void set_markers(logic [7:0] start_val, logic [7:0] end_val);
    start_mark = start_val;
    end_mark   = end_val;
  endfunction

  function int unsigned pending();
    return expected_beats.size();
  endfunction

  function void push_beat(logic [7:0] data, logic last, logic rej);
    frame_beat_t b;
    b.data = data;
    b.last = last;
    b.rej  = rej;
    expected_beats.push_back(b);
  endfunction

  function void close_frame();
    push_beat(cfb_pkg::CHK_BASE - running_sum, 1'b0, 1'b0);
    push_beat(end_mark, 1'b1, 1'b0);
    frame_live = 1'b0;
    remaining  = '0;
  endfunction

  function void note_input(logic cmd, logic [7:0] code, logic [5:0] len, logic [7:0] pbyte);
    if (cmd == cfb_pkg::CMD_OPEN) begin
      // oversize length: drop without touching the message counter
      if (len > cfb_pkg::MAX_PAYLOAD_DEF) begin
        push_beat(8'h00, 1'b0, 1'b1);
        return;
      end
      push_beat(start_mark, 1'b0, 1'b0);
      push_beat(cfb_pkg::LEN_OVERHEAD + {2'b00, len}, 1'b0, 1'b0);
      push_beat(next_id, 1'b0, 1'b0);
      push_beat(code, 1'b0, 1'b0);
      running_sum = next_id + code;
      next_id     = next_id + 8'd1;
      if (len == 6'd0) begin
        close_frame();
      end else begin
        frame_live = 1'b1;
        remaining  = len;
      end
    end else if (!frame_live || remaining == 6'd0) begin
      push_beat(8'h00, 1'b0, 1'b1);
    end else begin
      push_beat(pbyte, 1'b0, 1'b0);
      running_sum = running_sum + pbyte;
      remaining   = remaining - 6'd1;
      if (remaining == 6'd0) close_frame();
    end
  endfunction

  function void check_beat(logic [7:0] data, logic last, logic rej);
    frame_beat_t want;
    if (expected_beats.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected beat: byte %02h end %0b rej %0b", data, last, rej);
      return;
    end
    want = expected_beats.pop_front();
    if (data !== want.data || last !== want.last || rej !== want.rej) begin
      errors++;
      if (errors <= 10)
        $display("beat mismatch: expected byte %02h end %0b rej %0b, %s %02h end %0b rej %0b",
                 want.data, want.last, want.rej, "got byte", data, last, rej);
    end
  endfunction
endclass

module tb_command_frame_builder;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [7:0]  cmd_code_i;
  logic [5:0]  payload_length_i;
  logic [7:0]  payload_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic        rejected_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count;

  frame_scoreboard sb;

  command_frame_builder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .cmd_code_i       (cmd_code_i),
    .payload_length_i (payload_length_i),
    .payload_byte_i   (payload_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .frame_end_o      (frame_end_o),
    .rejected_o       (rejected_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check each accepted output beat, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat(out_byte_o, frame_end_o, rejected_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_command_frame_builder: errors");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [7:0] code, input logic [5:0] len,
                           input logic [7:0] pbyte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    cmd_code_i       <= code;
    payload_length_i <= len;
    payload_byte_i   <= pbyte;
    // hold the beat until the block takes it
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(cmd, code, len, pbyte);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_markers(input logic [7:0] start_val, input logic [7:0] end_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= cfb_pkg::CFG_START_MARKER;
    cfg_wdata_i <= start_val;
    @(posedge clk_i);
    cfg_idx_i   <= cfb_pkg::CFG_END_MARKER;
    cfg_wdata_i <= end_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_markers(start_val, end_val);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned n_bytes;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // stray byte, or an extra byte into an abandoned frame
        send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 10) begin
        send_item(cfb_pkg::CMD_OPEN, 8'($urandom),
                  6'($urandom_range(63, cfb_pkg::MAX_PAYLOAD_DEF + 1)), 8'($urandom));
        sent++;
      end else if (pick < 12) begin
        drain();
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      len = 0;
        else if (pick < 85) len = $urandom_range(3, 1);
        else if (pick < 95) len = $urandom_range(15, 4);
        else if (pick < 98) len = $urandom_range(cfb_pkg::MAX_PAYLOAD_DEF - 1, 16);
        else                len = cfb_pkg::MAX_PAYLOAD_DEF;
        n_bytes = len;
        // cut some frames short so the next open abandons them
        if (len > 1 && $urandom_range(99) < 8) n_bytes = $urandom_range(len - 1);
        send_item(cfb_pkg::CMD_OPEN, 8'($urandom), 6'(len), 8'($urandom));
        sent++;
        repeat (n_bytes) begin
          send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = cfb_pkg::CFG_START_MARKER;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    command_i        = cfb_pkg::CMD_OPEN;
    cmd_code_i       = '0;
    payload_length_i = '0;
    payload_byte_i   = '0;
    out_stall_i      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 35;
    recv_stall_pct = 68;

    // directed part, reset markers
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'h00);
    send_item(cfb_pkg::CMD_OPEN, 8'hFF, 6'd0, 8'($urandom));
    send_item(cfb_pkg::CMD_OPEN, 8'h00, 6'd63, 8'($urandom));
    send_item(cfb_pkg::CMD_OPEN, 8'h5A, 6'(cfb_pkg::MAX_PAYLOAD_DEF + 1), 8'($urandom));
    send_item(cfb_pkg::CMD_OPEN, 8'h00, 6'd1, 8'($urandom));
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'hFF);
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'h55);
    send_item(cfb_pkg::CMD_OPEN, 8'hA5, 6'd2, 8'($urandom));
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'h00);
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'hFF);
    // open a frame, then open another while the first is still waiting for payload
    send_item(cfb_pkg::CMD_OPEN, 8'h3C, 6'd3, 8'($urandom));
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'h12);
    send_item(cfb_pkg::CMD_OPEN, 8'hC3, 6'd0, 8'($urandom));
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'h77);
    send_item(cfb_pkg::CMD_OPEN, 8'h80, 6'd1, 8'($urandom));
    send_item(cfb_pkg::CMD_DATA, 8'($urandom), 6'($urandom), 8'h80);
    drain();

    write_markers(8'h00, 8'hFF);
    run_random(160);
    drain();

    send_idle_pct  = 68;
    recv_stall_pct = 35;
    write_markers(8'hFF, 8'h00);
    run_random(160);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_markers(8'($urandom), 8'($urandom));
    run_random(150);
    drain();

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_command_frame_builder: clean");
    else
      $display("tb_command_frame_builder: errors");
    $finish;
  end

endmodule
